[design/lwwpf_pkg.sv]
// ----------------------------------------------------------------------------
// Weak pixel finder package
// Shared types and constants for the label window weak pixel finder.
// ----------------------------------------------------------------------------
`default_nettype none

package lwwpf_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned DIM_W       = 11;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned MIN_DIM     = 3;
  localparam int unsigned MAX_HEIGHT  = 1024;
  localparam int unsigned IDX_W       = 20;
  localparam int unsigned OUT_LABEL_W = 16;
  localparam int unsigned RING_N      = 8;
  localparam int unsigned Q_DEPTH     = 4;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_NEIGHBOUR_LIMIT = 3'd2,
    CFG_COMBINED_LIMIT  = 3'd3,
    CFG_PAIR_INCREMENT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [3:0]        neighbour_limit;
    logic signed [5:0] combined_limit;
    logic signed [1:0] pair_increment;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]       index;
    logic [OUT_LABEL_W-1:0] label;
    logic                   moved;
    logic [RING_N-1:0]      hits;
  } q_entry_t;

endpackage

`default_nettype wire

[design/lwwpf_front.sv]
// ----------------------------------------------------------------------------
// Weak pixel finder front end
// Raster counters, two line stores and the 3x3 window; classifies each
// window centre with its ring and pushes judged pixels with a non-zero label.
// ----------------------------------------------------------------------------
`default_nettype none

module lwwpf_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned LABEL_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lwwpf_pkg::cfg_t                cfg_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [15:0]                    pixel_label_i,
  input  wire logic                           already_moved_i,
  input  wire logic [lwwpf_pkg::Q_CNT_W-1:0]  q_level_i,
  output logic                                push_o,
  output lwwpf_pkg::q_entry_t                 entry_o
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned W_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ENTRY_W = LABEL_BITS + 1;
  localparam int unsigned ROW_W   = lwwpf_pkg::ROW_W;
  localparam int unsigned IDX_W   = lwwpf_pkg::IDX_W;
  localparam int unsigned PROD_W  = (ROW_W + W_BITS > IDX_W) ? ROW_W + W_BITS : IDX_W;

  logic                          accept;
  logic [W_BITS-1:0]             w_eff;
  logic [lwwpf_pkg::DIM_W-1:0]   h_eff;
  logic [COL_W-1:0]              col_q, col_d;
  logic [ROW_W-1:0]              row_q, row_d;

  logic [ENTRY_W-1:0]            upper_mem [MAX_WIDTH];
  logic [ENTRY_W-1:0]            middle_mem [MAX_WIDTH];
  logic [ENTRY_W-1:0]            up_rd_q, mid_rd_q;

  logic                          v1_q, v2_q;
  logic [ENTRY_W-1:0]            px1_q;
  logic [COL_W-1:0]              col1_q, col2_q;
  logic [ROW_W-1:0]              row1_q;
  logic                          judge2_q;
  logic [PROD_W-1:0]             prod_q;

  logic [ENTRY_W-1:0]            win_q [3][3];
  logic [LABEL_BITS-1:0]         ring [lwwpf_pkg::RING_N];
  logic [LABEL_BITS-1:0]         centre;
  logic [lwwpf_pkg::Q_CNT_W:0]   pending;

  assign pending    = (lwwpf_pkg::Q_CNT_W + 1)'(q_level_i)
                    + (lwwpf_pkg::Q_CNT_W + 1)'(v1_q)
                    + (lwwpf_pkg::Q_CNT_W + 1)'(v2_q);
  assign in_stall_o = pending >= (lwwpf_pkg::Q_CNT_W + 1)'(lwwpf_pkg::Q_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (cfg_i.frame_width < lwwpf_pkg::DIM_W'(lwwpf_pkg::MIN_DIM)) begin
      w_eff = W_BITS'(lwwpf_pkg::MIN_DIM);
    end else if (32'(cfg_i.frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = W_BITS'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height < lwwpf_pkg::DIM_W'(lwwpf_pkg::MIN_DIM)) begin
      h_eff = lwwpf_pkg::DIM_W'(lwwpf_pkg::MIN_DIM);
    end else if (cfg_i.frame_height > lwwpf_pkg::DIM_W'(lwwpf_pkg::MAX_HEIGHT)) begin
      h_eff = lwwpf_pkg::DIM_W'(lwwpf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.frame_height;
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if ((W_BITS + 1)'(col_q) + (W_BITS + 1)'(1) >= (W_BITS + 1)'(w_eff)) begin
        col_d = '0;
        if (lwwpf_pkg::DIM_W'(row_q) + lwwpf_pkg::DIM_W'(1) >= h_eff) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= accept;
      v2_q  <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q <= upper_mem[col_q];
    end
    if (v1_q) begin
      upper_mem[col1_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rd_q <= middle_mem[col_q];
    end
    if (v1_q) begin
      middle_mem[col1_q] <= px1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q  <= {already_moved_i, LABEL_BITS'(pixel_label_i)};
      col1_q <= col_q;
      row1_q <= row_q;
    end
    if (v1_q) begin
      col2_q   <= col1_q;
      judge2_q <= (row1_q >= ROW_W'(2)) && (col1_q >= COL_W'(2));
      prod_q   <= PROD_W'(row1_q - ROW_W'(1)) * PROD_W'(w_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (v1_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_rd_q;
      win_q[1][2] <= mid_rd_q;
      win_q[2][2] <= px1_q;
    end
  end

  assign centre  = win_q[1][1][LABEL_BITS-1:0];
  assign ring[0] = win_q[1][0][LABEL_BITS-1:0];
  assign ring[1] = win_q[0][0][LABEL_BITS-1:0];
  assign ring[2] = win_q[0][1][LABEL_BITS-1:0];
  assign ring[3] = win_q[0][2][LABEL_BITS-1:0];
  assign ring[4] = win_q[1][2][LABEL_BITS-1:0];
  assign ring[5] = win_q[2][2][LABEL_BITS-1:0];
  assign ring[6] = win_q[2][1][LABEL_BITS-1:0];
  assign ring[7] = win_q[2][0][LABEL_BITS-1:0];

  always_comb begin
    for (int i = 0; i < lwwpf_pkg::RING_N; i++) begin
      entry_o.hits[i] = (ring[i] == centre);
    end
    entry_o.index = prod_q[IDX_W-1:0] + IDX_W'(col2_q - COL_W'(1));
    entry_o.label = lwwpf_pkg::OUT_LABEL_W'(centre);
    entry_o.moved = win_q[1][1][LABEL_BITS];
  end

  assign push_o = v2_q && judge2_q && (centre != '0);

endmodule

`default_nettype wire

[design/lwwpf_queue.sv]
// ----------------------------------------------------------------------------
// Weak pixel finder queue
// Short queue of judged pixels between the front end and the scorer.
// ----------------------------------------------------------------------------
`default_nettype none

module lwwpf_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire lwwpf_pkg::q_entry_t            entry_i,
  input  wire logic                           pop_i,
  output lwwpf_pkg::q_entry_t                 head_o,
  output logic                                empty_o,
  output logic [lwwpf_pkg::Q_CNT_W-1:0]       level_o
);

  lwwpf_pkg::q_entry_t                 slot_q [lwwpf_pkg::Q_DEPTH];
  logic [lwwpf_pkg::Q_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [lwwpf_pkg::Q_CNT_W-1:0]       count_q;

  assign head_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign level_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + lwwpf_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + lwwpf_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + lwwpf_pkg::Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - lwwpf_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/lwwpf_back.sv]
// ----------------------------------------------------------------------------
// Weak pixel finder scorer
// Counts matches and adjacent pairs, applies the limits and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lwwpf_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lwwpf_pkg::cfg_t      cfg_i,
  input  wire lwwpf_pkg::q_entry_t  head_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [19:0]               center_index_o,
  output logic [15:0]               center_label_o,
  output logic                      reassign_flag_o
);

  logic              out_valid_q;
  logic [19:0]       index_q;
  logic [15:0]       label_q;
  logic              flag_q;
  logic [3:0]        cnt, pcnt;
  logic signed [6:0] inc_s, lim_s, score;
  logic              flag;

  always_comb begin
    cnt   = 4'($countones(head_i.hits));
    pcnt  = 4'($countones(head_i.hits & {head_i.hits[0], head_i.hits[7:1]}));
    inc_s = {{5{cfg_i.pair_increment[1]}}, cfg_i.pair_increment};
    lim_s = {cfg_i.combined_limit[5], cfg_i.combined_limit};
    score = signed'({3'b000, cnt}) + signed'({3'b000, pcnt}) * inc_s;
    flag  = (cnt <= cfg_i.neighbour_limit) && (score <= lim_s) && !head_i.moved;
  end

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      index_q <= head_i.index;
      label_q <= head_i.label;
      flag_q  <= flag;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign center_index_o  = index_q;
  assign center_label_o  = label_q;
  assign reassign_flag_o = flag_q;

endmodule

`default_nettype wire

[design/label_window_weak_pixel_finder_unit.sv]
// ----------------------------------------------------------------------------
// Label window weak pixel finder
// A judged pixel passes through the window, queue and output register once
// the pixel completing its window is accepted. Throughput: one pixel per
// cycle if not stalled, set by one read and write port per line store.
// Reset clears the counters, window and queue and loads the configuration
// defaults; the line stores are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module label_window_weak_pixel_finder_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned LABEL_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [lwwpf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lwwpf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [15:0]                         pixel_label_i,
  input  wire logic                                already_moved_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [19:0]                              center_index_o,
  output logic [15:0]                              center_label_o,
  output logic                                     reassign_flag_o
);

  lwwpf_pkg::cfg_t                    cfg_q;
  lwwpf_pkg::q_entry_t                push_entry, head;
  logic                               push, pop, empty;
  logic [lwwpf_pkg::Q_CNT_W-1:0]      level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= 11'd640;
      cfg_q.frame_height    <= 11'd480;
      cfg_q.neighbour_limit <= 4'd4;
      cfg_q.combined_limit  <= 6'sd8;
      cfg_q.pair_increment  <= 2'sd1;
    end else if (cfg_we_i) begin
      case (lwwpf_pkg::cfg_idx_e'(cfg_idx_i))
        lwwpf_pkg::CFG_FRAME_WIDTH: begin
          cfg_q.frame_width <= cfg_data_i;
        end
        lwwpf_pkg::CFG_FRAME_HEIGHT: begin
          cfg_q.frame_height <= cfg_data_i;
        end
        lwwpf_pkg::CFG_NEIGHBOUR_LIMIT: begin
          cfg_q.neighbour_limit <= cfg_data_i[3:0];
        end
        lwwpf_pkg::CFG_COMBINED_LIMIT: begin
          cfg_q.combined_limit <= cfg_data_i[5:0];
        end
        lwwpf_pkg::CFG_PAIR_INCREMENT: begin
          cfg_q.pair_increment <= cfg_data_i[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lwwpf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_label_i   (pixel_label_i),
    .already_moved_i (already_moved_i),
    .q_level_i       (level),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  lwwpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .level_o (level)
  );

  lwwpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .center_index_o  (center_index_o),
    .center_label_o  (center_label_o),
    .reassign_flag_o (reassign_flag_o)
  );

endmodule

`default_nettype wire
